>>> hdl/glu_pkg.sv
// Shared types for the GCD / LCM unit.
`timescale 1ns / 1ps

package glu_pkg;

	// Top-level sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EUC_CHECK,
		ST_EUC_DIV,
		ST_LCM_DIV,
		ST_LCM_MUL,
		ST_FINISH
	} glu_state_t;

endpackage

>>> hdl/glu_if.sv
// Valid/ready channel interfaces for operand and result transfers.
`timescale 1ns / 1ps

interface glu_in_if #(parameter int DATA_WIDTH = 32);
	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] a_value;
	logic [DATA_WIDTH-1:0] b_value;

	modport source (output valid, output a_value, output b_value, input ready);
	modport sink   (input valid, input a_value, input b_value, output ready);
endinterface

interface glu_out_if #(parameter int DATA_WIDTH = 32);
	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] gcd_value;
	logic [DATA_WIDTH-2:0] lcm_value;
	logic                  lcm_overflow;

	modport source (output valid, output gcd_value, output lcm_value, output lcm_overflow,
		input ready);
	modport sink   (input valid, input gcd_value, input lcm_value, input lcm_overflow,
		output ready);
endinterface

>>> hdl/gcd_lcm_unit.sv
// One pair in flight at a time; Euclid remainder steps number at most about 46 at 32 bits.
// Each remainder step and the final divide take one bit-serial pass of the shared divider;
// the LCM product takes one multiplier pass. A zero operand skips both LCM passes.
// A finished result waits while the next pair is accepted.
// Reset (arst_n low, asynchronous) returns the sequencer to idle and clears all valids.
`timescale 1ns / 1ps

module gcd_lcm_unit
	import glu_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	glu_in_if.sink     in_ch,
	glu_out_if.source  out_ch
);

	glu_state_t state_q, state_d;

	logic [DATA_WIDTH-1:0] a_mag;
	logic [DATA_WIDTH-1:0] b_mag;
	logic [DATA_WIDTH-1:0] ma_q;
	logic [DATA_WIDTH-1:0] mb_q;
	logic [DATA_WIDTH-1:0] x_q;
	logic [DATA_WIDTH-1:0] y_q;
	logic [DATA_WIDTH-2:0] lcm_q;
	logic                  ovf_q;
	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] out_gcd_q;
	logic [DATA_WIDTH-2:0] out_lcm_q;
	logic                  out_ovf_q;

	logic                  in_xfer;
	logic                  out_load;
	logic                  div_start;
	logic [DATA_WIDTH-1:0] div_dividend;
	logic [DATA_WIDTH-1:0] div_divisor;
	logic                  div_done;
	logic [DATA_WIDTH-1:0] div_quo;
	logic [DATA_WIDTH-1:0] div_rem;
	logic                  mul_start;
	logic                  mul_done;
	logic [DATA_WIDTH-2:0] mul_prod;
	logic                  mul_ovf;
	logic                  any_zero;

	// Operand magnitudes as unsigned values
	assign a_mag = in_ch.a_value[DATA_WIDTH-1] ? (~in_ch.a_value + 1'b1) : in_ch.a_value;
	assign b_mag = in_ch.b_value[DATA_WIDTH-1] ? (~in_ch.b_value + 1'b1) : in_ch.b_value;
	assign any_zero = (ma_q == '0) || (mb_q == '0);

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_xfer     = in_ch.valid && in_ch.ready;

	glu_divider #(.DATA_WIDTH(DATA_WIDTH)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	glu_multiplier #(.DATA_WIDTH(DATA_WIDTH)) u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mul_start),
		.mcand    (div_quo),
		.mplier   (mb_q),
		.done     (mul_done),
		.product  (mul_prod),
		.overflow (mul_ovf)
	);

	// Next state and unit starts
	always_comb begin
		state_d      = state_q;
		div_start    = 1'b0;
		div_dividend = x_q;
		div_divisor  = y_q;
		mul_start    = 1'b0;
		out_load     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer)
					state_d = ST_EUC_CHECK;
			end
			ST_EUC_CHECK: begin
				if (y_q != '0) begin
					div_start = 1'b1;
					state_d   = ST_EUC_DIV;
				end else if (any_zero) begin
					state_d = ST_FINISH;
				end else begin
					div_start    = 1'b1;
					div_dividend = ma_q;
					div_divisor  = x_q;
					state_d      = ST_LCM_DIV;
				end
			end
			ST_EUC_DIV: begin
				if (div_done)
					state_d = ST_EUC_CHECK;
			end
			ST_LCM_DIV: begin
				if (div_done) begin
					mul_start = 1'b1;
					state_d   = ST_LCM_MUL;
				end
			end
			ST_LCM_MUL: begin
				if (mul_done)
					state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ch.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	// Advance the Euclid pair and capture results
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			ma_q <= a_mag;
			mb_q <= b_mag;
			x_q  <= a_mag;
			y_q  <= b_mag;
		end
		if (state_q == ST_EUC_DIV && div_done) begin
			x_q <= y_q;
			y_q <= div_rem;
		end
		if (state_q == ST_EUC_CHECK && y_q == '0 && any_zero) begin
			lcm_q <= '0;
			ovf_q <= 1'b0;
		end
		if (state_q == ST_LCM_MUL && mul_done) begin
			lcm_q <= mul_prod;
			ovf_q <= mul_ovf;
		end
		if (out_load) begin
			out_gcd_q <= x_q;
			out_lcm_q <= lcm_q;
			out_ovf_q <= ovf_q;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.gcd_value    = out_gcd_q;
	assign out_ch.lcm_value    = out_lcm_q;
	assign out_ch.lcm_overflow = out_ovf_q;

endmodule

>>> hdl/glu_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module glu_divider
	import glu_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DATA_WIDTH-1:0] dividend,
	input  logic [DATA_WIDTH-1:0] divisor,
	output logic                  done,
	output logic [DATA_WIDTH-1:0] quotient,
	output logic [DATA_WIDTH-1:0] remainder
);

	localparam int CW = $clog2(DATA_WIDTH + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CW-1:0]         cnt_q;
	logic [DATA_WIDTH-1:0] rem_q;
	logic [DATA_WIDTH-1:0] quo_q;
	logic [DATA_WIDTH-1:0] dsr_q;
	logic [DATA_WIDTH:0]   shifted;
	logic [DATA_WIDTH:0]   trial;
	logic                  fits;

	// Bring in the next dividend bit and try the subtraction
	always_comb begin
		shifted = {rem_q, quo_q[DATA_WIDTH-1]};
		trial   = shifted - {1'b0, dsr_q};
		fits    = !trial[DATA_WIDTH];
	end

	// Count steps and flag completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DATA_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift the partial remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
			quo_q <= {quo_q[DATA_WIDTH-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

>>> hdl/glu_multiplier.sv
// Bit-serial shift-add multiplier with saturation at the LCM limit.
`timescale 1ns / 1ps

module glu_multiplier
	import glu_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DATA_WIDTH-1:0] mcand,
	input  logic [DATA_WIDTH-1:0] mplier,
	output logic                  done,
	output logic [DATA_WIDTH-2:0] product,
	output logic                  overflow
);

	localparam int CW = $clog2(DATA_WIDTH + 1);
	localparam logic [DATA_WIDTH:0] LimitMax = {2'b00, {(DATA_WIDTH-1){1'b1}}};

	logic                  busy_q;
	logic                  done_q;
	logic                  ovf_q;
	logic [CW-1:0]         cnt_q;
	logic [DATA_WIDTH-1:0] mcand_q;
	logic [DATA_WIDTH-1:0] mplier_q;
	logic [DATA_WIDTH:0]   acc_q;
	logic [DATA_WIDTH:0]   acc_nxt;

	// Double the sum and add the multiplicand for the next multiplier bit, MSB first
	always_comb begin
		acc_nxt = {acc_q[DATA_WIDTH-1:0], 1'b0}
			+ (mplier_q[DATA_WIDTH-1] ? {1'b0, mcand_q} : '0);
	end

	// Count steps, track saturation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				ovf_q  <= 1'b0;
				cnt_q  <= CW'(DATA_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (!ovf_q && acc_nxt > LimitMax)
					ovf_q <= 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift the multiplier out and hold the sum once saturated
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= mcand;
			mplier_q <= mplier;
			acc_q    <= '0;
		end else if (busy_q) begin
			mplier_q <= {mplier_q[DATA_WIDTH-2:0], 1'b0};
			if (!ovf_q && acc_nxt <= LimitMax)
				acc_q <= acc_nxt;
		end
	end

	assign done     = done_q;
	assign overflow = ovf_q;
	assign product  = ovf_q ? LimitMax[DATA_WIDTH-2:0] : acc_q[DATA_WIDTH-2:0];

endmodule

>>> hdl/glu_checker.sv
// Port-level assertions for the GCD / LCM unit, bound to the top level.
`timescale 1ns / 1ps

module glu_checker #(
	parameter int DATA_WIDTH = 32
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [DATA_WIDTH-1:0] gcd_value,
	input logic [DATA_WIDTH-2:0] lcm_value,
	input logic                  lcm_overflow
);

	localparam logic [DATA_WIDTH-1:0] GcdMax = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	// Overflow always comes with the saturated LCM
	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && lcm_overflow |-> lcm_value == {(DATA_WIDTH-1){1'b1}})
		else $error("overflow without saturated lcm");

	// A nonzero LCM needs a nonzero GCD
	a_lcm_gcd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && lcm_value != '0 |-> gcd_value != '0)
		else $error("nonzero lcm with zero gcd");

	// GCD of magnitudes never exceeds the most negative magnitude
	a_gcd_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> gcd_value <= GcdMax)
		else $error("gcd out of range");

	// One pair at a time: after a transfer in, input is not ready
	a_one_pair: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after transfer");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(gcd_value) && $stable(lcm_value))
		else $error("stalled result changed");

endmodule

bind gcd_lcm_unit glu_checker #(.DATA_WIDTH(DATA_WIDTH)) u_glu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.gcd_value    (out_ch.gcd_value),
	.lcm_value    (out_ch.lcm_value),
	.lcm_overflow (out_ch.lcm_overflow)
);

>>> tb/testbench.sv
// Self-checking testbench for the GCD / LCM unit: directed table, then shaped random operands.
`timescale 1ns / 1ps

module testbench;

	localparam int DW           = 32;
	localparam int IDLE_PERCENT = 18;
	localparam int RANDOM_ITEMS = 800;
	localparam int QUIET_FIRST  = 300;
	localparam int QUIET_LAST   = 449;
	localparam int DRAIN_CYCLES = 2000;
	localparam int PRINT_LIMIT  = 40;
	localparam int DIRECTED_ROWS = 22;

	localparam logic [DW-2:0] LCM_LIMIT = '1;
	localparam logic [DW-1:0] MOST_NEG  = {1'b1, {(DW-1){1'b0}}};

	// Expected-result source for a directed row
	localparam logic EXP_PREDICTED = 1'b0;
	localparam logic EXP_TYPED     = 1'b1;

	typedef struct packed {
		logic [DW-1:0] gcd;
		logic [DW-2:0] lcm;
		logic          ovf;
	} gcd_lcm_t;

	typedef struct packed {
		logic [DW-1:0] a;
		logic [DW-1:0] b;
		logic          source;
		gcd_lcm_t      res;
	} operand_row_t;

	// Edge values: extremes, sign boundaries and powers of two
	localparam logic [DW-1:0] EDGE_VALUES [8] = '{
		32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
		32'h7FFF_FFFF, 32'h0001_0000, 32'h4000_0000, 32'hC000_0000
	};

	// Directed operand pairs; typed rows carry their own expected result
	localparam operand_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{32'h0000_0000, 32'h0000_0000, EXP_TYPED, '{32'h0000_0000, 31'h0, 1'b0}},
		'{32'h0000_0000, 32'h0000_0005, EXP_TYPED, '{32'h0000_0005, 31'h0, 1'b0}},
		'{-32'sd7,       32'h0000_0000, EXP_TYPED, '{32'h0000_0007, 31'h0, 1'b0}},
		'{32'h8000_0000, 32'h8000_0000, EXP_TYPED, '{32'h8000_0000, 31'h7FFF_FFFF, 1'b1}},
		'{32'h8000_0000, 32'h0000_0000, EXP_TYPED, '{32'h8000_0000, 31'h0, 1'b0}},
		'{32'h0000_0000, 32'h8000_0000, EXP_TYPED, '{32'h8000_0000, 31'h0, 1'b0}},
		'{32'h7FFF_FFFF, 32'h7FFF_FFFF, EXP_TYPED, '{32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0}},
		'{32'h7FFF_FFFF, 32'h8000_0000, EXP_TYPED, '{32'h0000_0001, 31'h7FFF_FFFF, 1'b1}},
		'{32'h0000_0001, 32'h0000_0001, EXP_TYPED, '{32'h0000_0001, 31'h1, 1'b0}},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, EXP_TYPED, '{32'h0000_0001, 31'h1, 1'b0}},
		'{32'd12,        -32'sd18,      EXP_TYPED, '{32'h0000_0006, 31'd36, 1'b0}},
		'{32'h0001_0000, 32'h0001_0000, EXP_TYPED, '{32'h0001_0000, 31'h1_0000, 1'b0}},
		'{32'h7FFF_FFFF, 32'h0000_0001, EXP_TYPED, '{32'h0000_0001, 31'h7FFF_FFFF, 1'b0}},
		'{32'd65537,     32'd65539,     EXP_PREDICTED, '0},
		'{32'd1836311903, 32'd1134903170, EXP_PREDICTED, '0},
		'{32'd46341,     -32'sd46341,   EXP_PREDICTED, '0},
		'{32'h8000_0000, 32'd2,         EXP_PREDICTED, '0},
		'{32'h8000_0000, -32'sd3,       EXP_PREDICTED, '0},
		'{32'h4000_0000, 32'd2,         EXP_PREDICTED, '0},
		'{32'h5555_5555, 32'hAAAA_AAAA, EXP_PREDICTED, '0},
		'{32'h0000_FFFF, 32'hFFFF_0000, EXP_PREDICTED, '0},
		'{32'd1073741823, 32'd2,        EXP_PREDICTED, '0}
	};

	logic clk;
	logic arst_n;
	logic idle_enabled;

	gcd_lcm_t pending_gcd_lcm[$];
	gcd_lcm_t want_res;
	int       mismatch_count;
	int       results_checked;
	int       pairs_sent;
	int       saturated_count;
	int       zero_operand_count;
	int       top_gcd_count;

	glu_in_if  #(.DATA_WIDTH(DW)) in_ch ();
	glu_out_if #(.DATA_WIDTH(DW)) out_ch ();

	gcd_lcm_unit #(.DATA_WIDTH(DW)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// Free-running clock, 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Magnitudes as unsigned, Euclid on the remainders, LCM as (|a|/g)*|b| with saturation
	function automatic gcd_lcm_t predict_gcd_lcm(input logic [DW-1:0] a, input logic [DW-1:0] b);
		logic [DW-1:0]   mag_a;
		logic [DW-1:0]   mag_b;
		logic [DW-1:0]   x;
		logic [DW-1:0]   y;
		logic [DW-1:0]   r;
		logic [2*DW-1:0] product;
		gcd_lcm_t        res;
		mag_a = a[DW-1] ? (~a + 1'b1) : a;
		mag_b = b[DW-1] ? (~b + 1'b1) : b;
		x = mag_a;
		y = mag_b;
		while (y != '0) begin
			r = x % y;
			x = y;
			y = r;
		end
		res.gcd = x;
		res.lcm = '0;
		res.ovf = 1'b0;
		if (mag_a != '0 && mag_b != '0) begin
			product = {{DW{1'b0}}, mag_a / x} * {{DW{1'b0}}, mag_b};
			if (product > {{(DW+1){1'b0}}, LCM_LIMIT}) begin
				res.lcm = LCM_LIMIT;
				res.ovf = 1'b1;
			end else begin
				res.lcm = product[DW-2:0];
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT) begin
			$display("MISMATCH @%0t: %s", $time, msg);
		end
	endtask

	// Present one operand pair, hold it until the transfer, queue the expected result
	task automatic push_operands(input logic [DW-1:0] a, input logic [DW-1:0] b,
		input logic source, input gcd_lcm_t typed_res);
		gcd_lcm_t res;
		while (idle_enabled && $urandom_range(0, 99) < IDLE_PERCENT) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.a_value <= a;
		in_ch.b_value <= b;
		@(posedge clk);
		while (!in_ch.ready) begin
			@(posedge clk);
		end
		res = (source == EXP_TYPED) ? typed_res : predict_gcd_lcm(a, b);
		pending_gcd_lcm.push_back(res);
		pairs_sent++;
		if (res.ovf) begin
			saturated_count++;
		end
		if (a == '0 || b == '0) begin
			zero_operand_count++;
		end
		if (res.gcd == MOST_NEG) begin
			top_gcd_count++;
		end
		@(negedge clk);
	endtask

	// Stall the result side at random
	always @(negedge clk) begin
		out_ch.ready <= !idle_enabled || ($urandom_range(0, 99) >= IDLE_PERCENT);
	end

	// Compare each result transfer with the oldest outstanding expectation
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_gcd_lcm.size() == 0) begin
				report_mismatch($sformatf("unexpected result gcd=%0d lcm=%0d ovf=%0b",
					out_ch.gcd_value, out_ch.lcm_value, out_ch.lcm_overflow));
			end else begin
				want_res = pending_gcd_lcm.pop_front();
				results_checked++;
				if (out_ch.gcd_value !== want_res.gcd) begin
					report_mismatch($sformatf("result %0d gcd_value %0d, expected %0d",
						results_checked, out_ch.gcd_value, want_res.gcd));
				end
				if (out_ch.lcm_value !== want_res.lcm) begin
					report_mismatch($sformatf("result %0d lcm_value %0d, expected %0d",
						results_checked, out_ch.lcm_value, want_res.lcm));
				end
				if (out_ch.lcm_overflow !== want_res.ovf) begin
					report_mismatch($sformatf("result %0d lcm_overflow %0b, expected %0b",
						results_checked, out_ch.lcm_overflow, want_res.ovf));
				end
			end
		end
	end

	// Main stimulus
	initial begin
		logic [DW-1:0] ra;
		logic [DW-1:0] rb;
		logic [DW-1:0] g;
		logic [DW-1:0] fib_hi;
		logic [DW-1:0] fib_lo;
		logic [DW-1:0] fib_next;
		int            pick;
		int            steps;
		clk                = 1'b0;
		arst_n             = 1'b0;
		idle_enabled       = 1'b1;
		in_ch.valid        = 1'b0;
		in_ch.a_value      = '0;
		in_ch.b_value      = '0;
		out_ch.ready       = 1'b0;
		mismatch_count     = 0;
		results_checked    = 0;
		pairs_sent         = 0;
		saturated_count    = 0;
		zero_operand_count = 0;
		top_gcd_count      = 0;

		// Hold reset, then release it
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Walk the directed table
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			push_operands(DIRECTED[i].a, DIRECTED[i].b, DIRECTED[i].source, DIRECTED[i].res);
		end

		// Drain everything before the random part
		in_ch.valid <= 1'b0;
		while (pending_gcd_lcm.size() != 0) begin
			@(negedge clk);
		end

		// Random operand pairs, shaped toward shared factors and long Euclid chains
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			idle_enabled = !(n >= QUIET_FIRST && n <= QUIET_LAST);
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				ra = $urandom;
				rb = $urandom;
			end else if (pick < 55) begin
				g  = $urandom_range(1, 65535);
				ra = g * $urandom_range(0, 32767);
				rb = g * $urandom_range(1, 32767);
			end else if (pick < 70) begin
				ra = $urandom_range(0, 255);
				rb = $urandom_range(0, 255);
			end else if (pick < 80) begin
				// Consecutive Fibonacci numbers give the longest remainder chains
				steps  = $urandom_range(1, 45);
				fib_hi = 1;
				fib_lo = 0;
				repeat (steps) begin
					fib_next = fib_hi + fib_lo;
					fib_lo   = fib_hi;
					fib_hi   = fib_next;
				end
				ra = fib_hi;
				rb = fib_lo;
			end else if (pick < 90) begin
				ra = EDGE_VALUES[$urandom_range(0, 7)];
				rb = $urandom_range(0, 1) ? EDGE_VALUES[$urandom_range(0, 7)] : $urandom;
			end else begin
				ra = $urandom_range(1, 65535);
				rb = ra * $urandom_range(1, 32767);
			end
			if ($urandom_range(0, 1)) begin
				g  = ra;
				ra = rb;
				rb = g;
			end
			if ($urandom_range(0, 1)) begin
				ra = -ra;
			end
			if ($urandom_range(0, 1)) begin
				rb = -rb;
			end
			push_operands(ra, rb, EXP_PREDICTED, '0);
		end
		in_ch.valid <= 1'b0;
		idle_enabled = 1'b1;

		// Wait out the last results, then watch for strays
		while (pending_gcd_lcm.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d operand pairs (%0d from the directed table), checked %0d results.",
			pairs_sent, DIRECTED_ROWS, results_checked);
		$display("Saw %0d saturated LCMs, %0d pairs with a zero operand, %0d with GCD 2^31.",
			saturated_count, zero_operand_count, top_gcd_count);
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Abort a hung run
	initial begin
		#(30_000_000);
		$display("Timeout: %0d results still outstanding", pending_gcd_lcm.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule

>>> sim.f
hdl/glu_pkg.sv
hdl/glu_if.sv
hdl/glu_divider.sv
hdl/glu_multiplier.sv
hdl/gcd_lcm_unit.sv
hdl/glu_checker.sv
tb/testbench.sv
